>>> design/wno_pkg.sv
// Package for the waveform and noise oscillator: payload structs, codes, constants.
// No dependencies.
package wno_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] phase_value;
    logic [31:0] seed_value;
  } wno_in_t;

  typedef struct packed {
    logic signed [17:0] sample_value;
    logic [31:0]        phase_now;
  } wno_out_t;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_PHASE = 2'd2;
  localparam logic [1:0] OP_SEED  = 2'd3;

  localparam logic [2:0] WK_SINE  = 3'd0;
  localparam logic [2:0] WK_SQUARE = 3'd1;
  localparam logic [2:0] WK_SAW   = 3'd2;
  localparam logic [2:0] WK_TRI   = 3'd3;
  localparam logic [2:0] WK_WHITE = 3'd4;
  localparam logic [2:0] WK_PINK  = 3'd5;

  localparam logic [2:0] REG_KIND  = 3'd0;
  localparam logic [2:0] REG_EN    = 3'd1;
  localparam logic [2:0] REG_START = 3'd2;
  localparam logic [2:0] REG_SWEEP = 3'd3;
  localparam logic [2:0] REG_END   = 3'd4;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // Horner divisors 110, 72, 42, 20, 6 as reciprocals, applied in order:
  // n / d == (n * (2^32 + recip)) >> shift for every n below 2^32
  function automatic logic [31:0] horner_recip(input logic [2:0] k);
    case (k)
      3'd0: horner_recip = 32'd702812831;
      3'd1: horner_recip = 32'd3340530120;
      3'd2: horner_recip = 32'd2249744775;
      3'd3: horner_recip = 32'd2576980378;
      3'd4: horner_recip = 32'd1431655766;
      default: horner_recip = 32'd0;
    endcase
  endfunction

  function automatic logic [5:0] horner_shift(input logic [2:0] k);
    case (k)
      3'd0: horner_shift = 6'd39;
      3'd1: horner_shift = 6'd39;
      3'd2: horner_shift = 6'd38;
      3'd3: horner_shift = 6'd37;
      3'd4: horner_shift = 6'd35;
      default: horner_shift = 6'd32;
    endcase
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_SINX, ST_SINX2, ST_HMUL, ST_HDIV, ST_SINS,
    ST_CSETUP, ST_CDIV, ST_CSQ, ST_NOISE, ST_PINKSUM, ST_FINISH, ST_OUT
  } wno_state_t;

endpackage

>>> design/waveform_and_noise_oscillator_core.sv
// Waveform and noise oscillator top level: sequencer, shared multiplier and divider.
// Depends on wno_pkg.
// Sequence, accepting edge to out_valid: non-tick opcodes give no result and leave
// the core in idle; a tick goes straight to the out state when disabled or an unused
// kind, through finish for triangle or a zero step, through one noise step for white
// noise, through corner setup (once for saw, twice for square) when no corner is hit,
// five Horner steps (one reciprocal multiply each) for sine, a 48-step divide per
// corner for saw and square, and one noise and one sum step per part for pink.
// After the out transfer the core returns to idle and takes the next item there.
module waveform_and_noise_oscillator_core
  import wno_pkg::*;
#(
  parameter int PINK_PARTS    = 8,
  parameter int SINE_LUT_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  wno_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output wno_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PB = (PINK_PARTS > 1) ? $clog2(PINK_PARTS) : 1;
  localparam int QB = SINE_LUT_BITS - 2;

  wno_state_t state_r, state_nxt;

  logic [2:0]  kind_r;
  logic        en_r;
  logic [30:0] end_r;
  logic [31:0] phase_r, step_r, seed_r, count_r;
  logic signed [32:0] rate_r;
  logic signed [17:0] pink_r [PINK_PARTS];

  logic [31:0] used_r;
  logic signed [31:0] acc_r;        // sample accumulator
  logic [31:0] x_r, x2_r;
  logic [31:0] t_r;
  logic [2:0]  k_r;
  logic [PB:0] pi_r;                // pink part index
  logic        corner_r;            // 0 corner at zero, 1 at half turn
  logic        neg_r;               // corner sign
  // shared restoring divider
  logic [47:0] num_r;
  logic [31:0] den_r;
  logic [47:0] quo_r;
  logic [32:0] rem_r;
  logic [5:0]  dcnt_r;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_valid = (state_r == ST_OUT);

  logic in_fire;
  assign in_fire = in_valid && in_ready;
  logic ticking;
  assign ticking = en_r && (kind_r <= WK_PINK);

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [31:0] xs;
  always_comb begin
    xs = seed_r ^ (seed_r << 13);
    xs = xs ^ (xs >> 17);
    xs = xs ^ (xs << 5);
  end

  logic [31:0] past;
  assign past = used_r - (corner_r ? 32'h8000_0000 : 32'h0);
  logic [16:0] pd;
  assign pd = 17'd65536 - quo_r[16:0];

  logic [32:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_r[31:0], num_r[47]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // Horner quotient by reciprocal: the implicit 2^32 of the reciprocal adds n << 32
  logic [64:0] hsum, hq;
  assign hsum = {1'b0, mul_p} + {1'b0, num_r[31:0], 32'd0};
  assign hq   = hsum >> horner_shift(k_r);

  logic [63:0] sin_s;
  always_comb begin
    sin_s = ((mul_p >> 30) + 64'd8192) >> 14;
    if (sin_s > 64'd65536) sin_s = 64'd65536;
  end

  logic [QB-1:0] fidx;
  logic [QB:0]   fval;
  logic [1:0]    quad;
  assign fidx = used_r[32-SINE_LUT_BITS +: QB];
  assign quad = used_r[31:30];
  assign fval = quad[0] ? ((QB+1)'(1) << QB) - {1'b0, fidx} : {1'b0, fidx};

  logic signed [35:0] pink_sum;
  logic signed [35:0] pink_div;
  assign pink_sum = 36'(acc_r);
  assign pink_div = pink_sum / PINK_PARTS;

  always_comb begin
    mul_a = x_r;
    mul_b = x_r;
    case (state_r)
      ST_SINX:  begin mul_a = 32'(fval); mul_b = PI_Q30; end
      ST_SINX2: begin mul_a = x_r; mul_b = x_r; end
      ST_HMUL:  begin mul_a = x2_r; mul_b = t_r; end
      ST_HDIV:  begin mul_a = num_r[31:0]; mul_b = horner_recip(k_r); end
      ST_SINS:  begin mul_a = x_r; mul_b = t_r; end
      ST_CSQ:   begin mul_a = 32'(pd); mul_b = 32'(pd); end
      default:  begin mul_a = x_r; mul_b = x_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire && in_data.opcode == OP_TICK) begin
        if (!ticking) state_nxt = ST_OUT;
        else case (kind_r)
          WK_SINE: state_nxt = ST_SINX;
          WK_SQUARE, WK_SAW: state_nxt = (step_r == 32'd0) ? ST_FINISH : ST_CSETUP;
          WK_WHITE, WK_PINK: state_nxt = ST_NOISE;
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_SINX:  state_nxt = ST_SINX2;
      ST_SINX2: state_nxt = ST_HMUL;
      ST_HMUL:  state_nxt = ST_HDIV;
      ST_HDIV:  state_nxt = (k_r == 3'd4) ? ST_SINS : ST_HMUL;
      ST_SINS:  state_nxt = ST_FINISH;
      ST_CSETUP: begin
        if (past < step_r || {1'b0, past} > (33'h1_0000_0000 - {1'b0, step_r}))
          state_nxt = ST_CDIV;
        else if (kind_r == WK_SQUARE && !corner_r) state_nxt = ST_CSETUP;
        else state_nxt = ST_FINISH;
      end
      ST_CDIV:  if (dcnt_r == 6'd0) state_nxt = ST_CSQ;
      ST_CSQ:   state_nxt = (kind_r == WK_SQUARE && !corner_r) ? ST_CSETUP : ST_FINISH;
      ST_NOISE: begin
        if (kind_r == WK_WHITE) state_nxt = ST_FINISH;
        else if (pi_r == (PB+1)'(PINK_PARTS - 1)) state_nxt = ST_PINKSUM;
      end
      ST_PINKSUM: if (pi_r == (PB+1)'(PINK_PARTS - 1)) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  logic signed [33:0] ns;
  assign ns = $signed({2'b00, step_r}) + 34'(rate_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r <= '0; en_r <= 1'b0; end_r <= '0;
      phase_r <= '0; step_r <= '0; rate_r <= '0; seed_r <= 32'd1; count_r <= '0;
      for (int i = 0; i < PINK_PARTS; i++) pink_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              REG_KIND:  kind_r <= cfg_data[2:0];
              REG_EN:    en_r <= cfg_data[0];
              REG_START: step_r <= {1'b0, cfg_data[30:0]};
              REG_SWEEP: rate_r <= 33'(signed'(cfg_data));
              REG_END:   end_r <= cfg_data[30:0];
              default: ;
            endcase
          end
          if (in_fire) begin
            used_r <= phase_r;
            acc_r <= '0;
            corner_r <= 1'b0;
            k_r <= '0;
            pi_r <= '0;
            t_r <= ONE_Q30;
            case (in_data.opcode)
              OP_RESET: begin
                phase_r <= '0; count_r <= '0;
                for (int i = 0; i < PINK_PARTS; i++) pink_r[i] <= '0;
              end
              OP_PHASE: phase_r <= in_data.phase_value;
              OP_SEED:  seed_r <= (in_data.seed_value == 32'd0) ? 32'd1
                                                                : in_data.seed_value;
              default: begin
                if (ticking) begin
                  case (kind_r)
                    WK_SQUARE: acc_r <= phase_r[31] ? -32'sd65536 : 32'sd65536;
                    WK_SAW: acc_r <= $signed({15'd0, phase_r[31:15]}) - 32'sd65536;
                    WK_TRI: acc_r <= phase_r[31] ?
                      32'sd196608 - $signed({14'd0, phase_r[31:14]}) :
                      $signed({14'd0, phase_r[31:14]}) - 32'sd65536;
                    default: ;
                  endcase
                end
              end
            endcase
          end
        end
        ST_SINX:  x_r <= 32'(mul_p >> (SINE_LUT_BITS - 1));
        ST_SINX2: x2_r <= 32'(mul_p >> 30);
        ST_HMUL:  num_r <= {16'd0, 32'(mul_p >> 30)};
        ST_HDIV: begin
          t_r <= ONE_Q30 - hq[31:0];
          k_r <= k_r + 3'd1;
        end
        ST_CDIV: begin
          num_r <= {num_r[46:0], 1'b0};
          if (!rem_sub[32]) begin
            rem_r <= rem_sub; quo_r <= {quo_r[46:0], 1'b1};
          end else begin
            rem_r <= rem_sh; quo_r <= {quo_r[46:0], 1'b0};
          end
          if (dcnt_r != 6'd0) dcnt_r <= dcnt_r - 6'd1;
        end
        ST_SINS: acc_r <= quad[1] ? -$signed(sin_s[31:0]) : $signed(sin_s[31:0]);
        ST_CSETUP: begin
          if (past < step_r) begin
            neg_r <= 1'b1;
            num_r <= {past, 16'd0};
          end else begin
            neg_r <= 1'b0;
            num_r <= {(32'd0 - past), 16'd0};
          end
          den_r <= step_r; rem_r <= '0; quo_r <= '0; dcnt_r <= 6'd47;
          if (!(past < step_r ||
                {1'b0, past} > (33'h1_0000_0000 - {1'b0, step_r})))
            corner_r <= 1'b1;
        end
        ST_CSQ: begin
          // square adds the zero corner and subtracts the half-turn one, sawtooth subtracts
          // its zero corner; a set neg_r flips the sign
          if ((kind_r == WK_SQUARE && !corner_r) ^ neg_r)
            acc_r <= acc_r + $signed({14'd0, mul_p[33:16]});
          else
            acc_r <= acc_r - $signed({14'd0, mul_p[33:16]});
          corner_r <= 1'b1;
        end
        ST_NOISE: begin
          if (kind_r == WK_WHITE) begin
            seed_r <= xs;
            acc_r <= $signed({15'd0, xs[31:15]}) - 32'sd65536;
          end else begin
            if ((count_r & ((32'd1 << pi_r) - 32'd1)) == 32'd0) begin
              seed_r <= xs;
              pink_r[pi_r[PB-1:0]] <= 18'($signed({15'd0, xs[31:15]}) - 32'sd65536);
            end
            pi_r <= (pi_r == (PB+1)'(PINK_PARTS - 1)) ? '0 : pi_r + 1'b1;
          end
        end
        ST_PINKSUM: begin
          acc_r <= acc_r + 32'(pink_r[pi_r[PB-1:0]]);
          pi_r <= pi_r + 1'b1;
        end
        ST_FINISH: begin
          if (kind_r == WK_PINK) acc_r <= 32'(pink_div);
          if (kind_r <= WK_TRI) begin
            phase_r <= used_r + step_r;
            if (rate_r != '0) begin
              if ((!rate_r[32] && ns >= $signed({3'b000, end_r})) ||
                  (rate_r[32] && ns <= $signed({3'b000, end_r}))) begin
                step_r <= {1'b0, end_r}; rate_r <= '0;
              end else step_r <= ns[31:0];
            end
          end
          count_r <= count_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data.phase_now = used_r;
    if (acc_r > 32'sd131071) out_data.sample_value = 18'sd131071;
    else if (acc_r < -32'sd131072) out_data.sample_value = -18'sd131072;
    else out_data.sample_value = acc_r[17:0];
  end

endmodule
